>>> src/shift_jis_to_iso2022jp_stream_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Shift-JIS to ISO-2022-JP stream converter
// Concurrent assertion wrappers clocked on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef SHIFT_JIS_TO_ISO2022JP_STREAM_DEFINES_SVH
`define SHIFT_JIS_TO_ISO2022JP_STREAM_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SJIS2JP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SJIS2JP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/sjis2jp_pkg.sv
// ----------------------------------------------------------------------------
// sjis2jp_pkg
// Shared constants, command type and pair conversion for the converter.
// ----------------------------------------------------------------------------
package sjis2jp_pkg;

  localparam logic [7:0] ESC_BYTE  = 8'h1b;
  localparam logic [7:0] DOLLAR    = 8'h24;
  localparam logic [7:0] PAREN     = 8'h28;
  localparam logic [7:0] LETTER_B  = 8'h42;
  localparam logic [7:0] TERM_BYTE = 8'h00;

  // Command queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Positions in the output sequence of one command
  localparam logic [2:0] POS_ESC  = 3'd0;
  localparam logic [2:0] POS_MID  = 3'd1;
  localparam logic [2:0] POS_FIN  = 3'd2;
  localparam logic [2:0] POS_D0   = 3'd3;
  localparam logic [2:0] POS_D1   = 3'd4;
  localparam logic [2:0] DATA_OFS = 3'd3;

  // One queued command: optional escape, then one or two data bytes
  typedef struct packed {
    logic       esc;
    logic [7:0] mid;
    logic       two;
    logic [7:0] d0;
    logic [7:0] d1;
  } cmd_t;

  function automatic logic is_lead(input logic [7:0] b);
    return ((b >= 8'h81) && (b <= 8'h9f)) || ((b >= 8'he0) && (b <= 8'hfc));
  endfunction

  // Lead/trail pair to JIS X 0208 code; zero for an invalid pair
  function automatic logic [15:0] pair_to_jis(input logic [7:0] lead,
                                              input logic [7:0] trail);
    logic [7:0] hi;
    logic [7:0] lo;
    logic       bad;
    bad = !is_lead(lead) || (trail < 8'h40) || (trail == 8'h7f) || (trail > 8'hfc);
    hi  = (lead >= 8'he0) ? (lead - 8'h40) : lead;
    hi  = ((hi - 8'h81) << 1) + 8'h21;
    lo  = (trail > 8'h7f) ? (trail - 8'h01) : trail;
    if (lo >= 8'h9e) begin
      lo = lo - 8'h7d;
      hi = hi + 8'h01;
    end else begin
      lo = lo - 8'h1f;
    end
    if (hi > 8'h7e) begin
      bad = 1'b1;
    end
    return bad ? 16'h0000 : {hi, lo};
  endfunction

endpackage

>>> src/sjis2jp_in_if.sv
// ----------------------------------------------------------------------------
// sjis2jp_in_if
// Request channel carrying one Shift-JIS source byte.
// ----------------------------------------------------------------------------
interface sjis2jp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

>>> src/sjis2jp_out_if.sv
// ----------------------------------------------------------------------------
// sjis2jp_out_if
// Request channel carrying one JIS output byte and its last mark.
// ----------------------------------------------------------------------------
interface sjis2jp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

>>> src/sjis2jp_front.sv
// ----------------------------------------------------------------------------
// sjis2jp_front
// Accepts source bytes, tracks lead and mode state, and queues commands.
// ----------------------------------------------------------------------------
module sjis2jp_front
  import sjis2jp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] text_byte_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

`include "shift_jis_to_iso2022jp_stream_defines.svh"

  logic [7:0] held_lead_q, held_lead_d;
  logic       lead_pending_q, lead_pending_d;
  logic       kanji_q, kanji_d;
  logic       take;
  logic [15:0] jis;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign jis        = pair_to_jis(held_lead_q, text_byte_i);

  always_comb begin
    held_lead_d    = held_lead_q;
    lead_pending_d = lead_pending_q;
    kanji_d        = kanji_q;
    push_o         = 1'b0;
    cmd_o.esc      = kanji_q;
    cmd_o.mid      = PAREN;
    cmd_o.two      = 1'b0;
    cmd_o.d0       = text_byte_i;
    cmd_o.d1       = jis[7:0];
    if (text_byte_i == TERM_BYTE) begin
      // drop any held lead, close the run, emit the terminator
      push_o         = take;
      held_lead_d    = 8'h00;
      lead_pending_d = 1'b0;
      kanji_d        = 1'b0;
    end else if (lead_pending_q) begin
      push_o         = take;
      cmd_o.esc      = !kanji_q;
      cmd_o.mid      = DOLLAR;
      cmd_o.two      = 1'b1;
      cmd_o.d0       = jis[15:8];
      held_lead_d    = 8'h00;
      lead_pending_d = 1'b0;
      kanji_d        = 1'b1;
    end else if (is_lead(text_byte_i)) begin
      // hold the lead until its trail arrives
      held_lead_d    = text_byte_i;
      lead_pending_d = 1'b1;
    end else begin
      push_o         = take;
      kanji_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lead_q    <= 8'h00;
      lead_pending_q <= 1'b0;
      kanji_q        <= 1'b0;
    end else if (take) begin
      held_lead_q    <= held_lead_d;
      lead_pending_q <= lead_pending_d;
      kanji_q        <= kanji_d;
    end
  end

  `SJIS2JP_ASSERT(a_held_is_lead, lead_pending_q |-> is_lead(held_lead_q), "held byte is no lead")

endmodule

>>> src/sjis2jp_queue.sv
// ----------------------------------------------------------------------------
// sjis2jp_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sjis2jp_queue
  import sjis2jp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic avail_o,
  output cmd_t head_o
);

`include "shift_jis_to_iso2022jp_stream_defines.svh"

  cmd_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign avail_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `SJIS2JP_ASSERT(a_count_bound, count_q <= QCNT_W'(QDEPTH), "queue count overflow")
  `SJIS2JP_ASSERT(a_no_push_full, !(push_i && full_o && !pop_i), "push into full queue")
  `SJIS2JP_ASSERT(a_no_pop_empty, !(pop_i && !avail_o), "pop from empty queue")

endmodule

>>> src/sjis2jp_back.sv
// ----------------------------------------------------------------------------
// sjis2jp_back
// Sequences each queued command into output bytes, one per cycle unless out_ready_i stalls the output.
// ----------------------------------------------------------------------------
module sjis2jp_back
  import sjis2jp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       avail_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  input  logic       out_ready_i
);

`include "shift_jis_to_iso2022jp_stream_defines.svh"

  logic [2:0] idx_q;
  logic [2:0] pos;
  logic [7:0] sel_byte;
  logic       sel_last;
  logic       load;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  assign pos      = head_i.esc ? idx_q : (idx_q + DATA_OFS);
  assign sel_last = (pos == (head_i.two ? POS_D1 : POS_D0));
  assign load     = avail_i && (!out_valid_q || out_ready_i);
  assign pop_o    = load && sel_last;

  always_comb begin
    case (pos)
      POS_ESC: sel_byte = ESC_BYTE;
      POS_MID: sel_byte = head_i.mid;
      POS_FIN: sel_byte = LETTER_B;
      POS_D0:  sel_byte = head_i.d0;
      default: sel_byte = head_i.d1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= sel_last ? 3'd0 : (idx_q + 3'd1);
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= sel_byte;
      out_last_q <= sel_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;

  `SJIS2JP_ASSERT(a_pop_marks_last, pop_o |=> (out_valid_q && out_last_q), "pop without last mark")

endmodule

>>> src/shift_jis_to_iso2022jp_stream.sv
// ----------------------------------------------------------------------------
// shift_jis_to_iso2022jp_stream
// Shift-JIS to 7-bit JIS (ISO-2022-JP) byte stream converter, top level.
// ----------------------------------------------------------------------------
// The converter takes one Shift-JIS byte per cycle on in_i and emits JIS bytes,
// escapes included, on out_o, one per cycle unless out_o.ready stalls it;
// run_last marks the final byte that a source byte causes, and a lead byte
// causes none until its trail arrives. A source byte is accepted in the cycle
// it is offered whenever the four-entry command queue has room; a kanji pair
// entering a run yields five output bytes, a byte leaving a run four, a pair
// inside a run two and any other byte one, so sustained throughput is set by
// the output sequencer at one byte a cycle while out_o is ready.
module shift_jis_to_iso2022jp_stream
  import sjis2jp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sjis2jp_in_if.sink           in_i,
  sjis2jp_out_if.source        out_o
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_avail;
  cmd_t q_head;

  // Classify each request and hold lead/mode state
  sjis2jp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .text_byte_i (in_i.text_byte),
    .in_ready_o  (in_i.ready),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .cmd_o       (q_cmd)
  );

  // Decouple the front from output stalls and escape bursts
  sjis2jp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .head_o  (q_head)
  );

  // Advance through escape and data bytes into the output register
  sjis2jp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (q_avail),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .run_last_o  (out_o.run_last),
    .out_ready_i (out_o.ready)
  );

endmodule
